### hw/rtl/bsm_pkg.sv
// Shared types and constants for the bitmap set membership engine.
// No dependencies; imported by the control, top level and checker files.
package bsm_pkg;

   localparam int OPCODE_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 21;
   localparam int LIMIT_W    = 20;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 40;   // opcode + member_value, padded to whole bytes
   localparam int RSP_DATA_W = 32;   // status + is_member + member_total + dirty_flag

   // bitmap word width: a power of two and a multiple of eight
   localparam int WORD_BITS  = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_ONLY = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TEST     = 3'd0,
      OP_ADD      = 3'd1,
      OP_REMOVE   = 3'd2,
      OP_CLEAR    = 3'd3,
      OP_COUNT    = 3'd4,
      OP_VALIDATE = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_ADDED     = 3'd1,
      STATUS_PRESENT   = 3'd2,
      STATUS_REMOVED   = 3'd3,
      STATUS_NOT_FOUND = 3'd4,
      STATUS_READ_ONLY = 3'd5,
      STATUS_INVALID   = 3'd6,
      STATUS_CORRUPT   = 3'd7
   } status_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] max_value;
      logic               read_only;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic               is_member;
      logic [COUNT_W-1:0] member_total;
      logic               dirty_flag;
   } result_type;

endpackage

### hw/rtl/bitmap_set_membership_engine.sv
// Test, add and remove accept the request, then read-modify-write one RAM word; the
// result goes via the result slot in bsm_ctrl and the output register to rsp. Count,
// unused opcodes and a refused clear take the same path. Clear and validate walk the
// bitmap RAM one word per cycle (NWORDS = DOMAIN_BITS/WORD_BITS); validate then waits
// for its popcount pipeline to empty. After reset, a clearing pass over every word holds
// req_tready low; configuration writes are taken throughout. Uses bsm_pkg, bsm_ctrl, bsm_ram.
module bitmap_set_membership_engine import bsm_pkg::*; #(
   parameter int DOMAIN_BITS = 1048576
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // opcode[2:0], member_value[34:3]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // status[2:0], is_member[3],
                                              // member_total[24:4], dirty_flag[25]
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [LIMIT_W-1:0]    csr_wdata
);

   localparam int NWORDS = (DOMAIN_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   cfg_type                cfg_ff, cfg_in;
   logic                   rsp_vld_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic                   res_valid;
   logic                   res_ready;
   result_type             res;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [WORD_BITS-1:0]   mem_wdata;
   logic                   mem_re;
   logic [ADDR_W-1:0]      mem_raddr;
   logic [WORD_BITS-1:0]   mem_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_VALUE: cfg_in.max_value = csr_wdata;
            CSR_READ_ONLY: cfg_in.read_only = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // output register: the result slot in bsm_ctrl drains into it
   assign res_ready = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '{LIMIT_RESET, 1'b0};
         rsp_vld_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (res_ready) begin
            rsp_vld_ff <= res_valid;
         end
      end
      if (res_ready && res_valid) begin
         rsp_data_ff <= RSP_DATA_W'({res.dirty_flag, res.member_total,
                                     res.is_member, res.status});
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   bsm_ctrl #(
      .DOMAIN_BITS (DOMAIN_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tdata[OPCODE_W-1:0]),
      .req_value  (req_tdata[OPCODE_W +: VALUE_W]),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   bsm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NWORDS)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

### hw/rtl/bsm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module bsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bsm_ctrl.sv
// Sequencer of the membership engine: single-bit read-modify-write, clear and
// validate sweeps over the bitmap RAM, member count and dirty mark. Uses bsm_pkg.
module bsm_ctrl import bsm_pkg::*; #(
   parameter int DOMAIN_BITS = 1048576,
   localparam int NWORDS = (DOMAIN_BITS + WORD_BITS - 1) / WORD_BITS,
   localparam int ADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [VALUE_W-1:0]   req_value,
   output logic                 mem_we,
   output logic [ADDR_W-1:0]    mem_waddr,
   output logic [WORD_BITS-1:0] mem_wdata,
   output logic                 mem_re,
   output logic [ADDR_W-1:0]    mem_raddr,
   input  logic [WORD_BITS-1:0] mem_rdata,
   output logic                 res_valid,
   input  logic                 res_ready,
   output result_type           res
);

   // WORD_BITS is a power of two and a multiple of eight
   localparam int BIT_W   = $clog2(WORD_BITS);
   localparam int NBYTES  = WORD_BITS / 8;
   localparam int WSUM_W  = $clog2(WORD_BITS + 1);
   localparam int TOT_W   = $clog2(DOMAIN_BITS + 1);
   localparam int CMP_W   = (TOT_W > COUNT_W) ? TOT_W : COUNT_W;
   localparam int LIM_CAP = DOMAIN_BITS - 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NWORDS - 1);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_MODIFY,
      ST_CLEAR,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   function automatic logic [3:0] pop8(input logic [7:0] b);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(b[i]);
      end
      return n;
   endfunction

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic                 ok_ff, ok_in;
   logic [BIT_W-1:0]     bsel_ff, bsel_in;
   logic [ADDR_W-1:0]    widx_ff, widx_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 mark_ff, mark_in;
   logic                 res_vld_ff, res_vld_in;
   result_type           res_ff, res_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic                 rd_pend_ff;
   logic                 pop_vld_ff;
   logic [3:0]           byte_cnt_ff [NBYTES];
   logic [WSUM_W-1:0]    wsum;

   logic [VALUE_W-1:0]   limit;
   logic                 num_ok;
   logic [ADDR_W-1:0]    req_widx;
   logic                 present;
   logic [WORD_BITS-1:0] bit_mask;
   status_type           status;
   logic                 member;

   // Effective limit: configured maximum capped at the top of the domain
   always_comb begin
      if (VALUE_W'(LIM_CAP) < VALUE_W'(cfg.max_value)) begin
         limit = VALUE_W'(LIM_CAP);
      end else begin
         limit = VALUE_W'(cfg.max_value);
      end
      num_ok   = (req_value <= limit);
      req_widx = ADDR_W'(req_value >> BIT_W);
   end

   always_comb begin
      wsum = '0;
      for (int i = 0; i < NBYTES; i++) begin
         wsum = wsum + WSUM_W'(byte_cnt_ff[i]);
      end
   end

   assign present  = mem_rdata[bsel_ff];
   assign bit_mask = WORD_BITS'(1) << bsel_ff;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      ok_in      = ok_ff;
      bsel_in    = bsel_ff;
      widx_in    = widx_ff;
      ptr_in     = ptr_ff;
      count_in   = count_ff;
      mark_in    = mark_ff;
      res_vld_in = res_vld_ff && !res_ready;
      res_in     = res_ff;
      total_in   = pop_vld_ff ? (total_ff + TOT_W'(wsum)) : total_ff;
      mem_we     = 1'b0;
      mem_waddr  = ptr_ff;
      mem_wdata  = '0;
      mem_re     = 1'b0;
      mem_raddr  = req_widx;
      req_ready  = 1'b0;
      status     = STATUS_OK;
      member     = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            // zero one word per cycle after reset
            mem_we = 1'b1;
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            req_ready = !res_vld_ff || res_ready;
            if (req_valid && req_ready) begin
               op_in    = opcode_type'(req_opcode);
               ok_in    = num_ok;
               bsel_in  = req_value[BIT_W-1:0];
               widx_in  = req_widx;
               total_in = '0;
               mem_re   = 1'b1;
               if (opcode_type'(req_opcode) == OP_CLEAR && !cfg.read_only) begin
                  state_in = ST_CLEAR;
               end else if (opcode_type'(req_opcode) == OP_VALIDATE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            // word of the addressed number is on mem_rdata now
            mem_waddr = widx_ff;
            case (op_ff)
               OP_TEST: begin
                  if (!ok_ff) begin
                     status = STATUS_INVALID;
                  end else begin
                     member = present;
                  end
               end
               OP_ADD: begin
                  if (cfg.read_only) begin
                     status = STATUS_READ_ONLY;
                  end else if (!ok_ff) begin
                     status = STATUS_INVALID;
                  end else if (present) begin
                     status = STATUS_PRESENT;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = mem_rdata | bit_mask;
                     count_in  = count_ff + COUNT_W'(1);
                     mark_in   = 1'b1;
                     status    = STATUS_ADDED;
                  end
               end
               OP_REMOVE: begin
                  if (cfg.read_only) begin
                     status = STATUS_READ_ONLY;
                  end else if (!ok_ff) begin
                     status = STATUS_INVALID;
                  end else if (!present) begin
                     status = STATUS_NOT_FOUND;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = mem_rdata & ~bit_mask;
                     count_in  = count_ff - COUNT_W'(1);
                     mark_in   = 1'b1;
                     status    = STATUS_REMOVED;
                  end
               end
               OP_CLEAR: begin
                  // only reaches here when refused
                  status = STATUS_READ_ONLY;
               end
               default: begin
                  status = STATUS_OK;
               end
            endcase
            res_in     = '{status, member, count_in, mark_in};
            res_vld_in = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (ptr_ff == LAST_ADDR) begin
               ptr_in     = '0;
               count_in   = '0;
               mark_in    = 1'b1;
               res_in     = '{STATUS_OK, 1'b0, '0, 1'b1};
               res_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_SCAN: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_ff;
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the popcount pipeline to empty, then compare
            if (!rd_pend_ff && !pop_vld_ff) begin
               if (CMP_W'(count_ff) > CMP_W'(DOMAIN_BITS) ||
                   CMP_W'(total_ff) != CMP_W'(count_ff)) begin
                  status = STATUS_CORRUPT;
               end
               res_in     = '{status, 1'b0, count_ff, mark_ff};
               res_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         ptr_ff     <= '0;
         count_ff   <= '0;
         mark_ff    <= 1'b0;
         res_vld_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         pop_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         count_ff   <= count_in;
         mark_ff    <= mark_in;
         res_vld_ff <= res_vld_in;
         rd_pend_ff <= (state_ff == ST_SCAN);
         pop_vld_ff <= rd_pend_ff;
      end
      op_ff    <= op_in;
      ok_ff    <= ok_in;
      bsel_ff  <= bsel_in;
      widx_ff  <= widx_in;
      res_ff   <= res_in;
      total_ff <= total_in;
   end

   // Validate pipeline, first stage: per-byte popcount of the returned word
   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         for (int i = 0; i < NBYTES; i++) begin
            byte_cnt_ff[i] <= pop8(mem_rdata[8*i +: 8]);
         end
      end
   end

   assign res_valid = res_vld_ff;
   assign res       = res_ff;

endmodule

### hw/rtl/bsm_checker.sv
// Port-level checks for bitmap_set_membership_engine, attached by bind below.
// Uses bsm_pkg for widths and status codes.
module bsm_checker import bsm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   status_type rsp_status;

   assign rsp_status = status_type'(rsp_tdata[STATUS_W-1:0]);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // after reset the store is being cleared: no transfer either way
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block active right after reset");

   // a successful add or remove marks the store dirty
   a_dirty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == STATUS_ADDED || rsp_status == STATUS_REMOVED)
      |-> rsp_tdata[STATUS_W + 1 + COUNT_W])
      else $error("store change without dirty flag");

   // membership is only reported by a successful test
   a_member: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[STATUS_W] |-> rsp_status == STATUS_OK)
      else $error("is_member set with error status");

   // a transferred request carries a known opcode
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !$isunknown(req_tdata[OPCODE_W-1:0]))
      else $error("unknown opcode transferred");

endmodule

bind bitmap_set_membership_engine bsm_checker u_bsm_checker (.*);
